/* hw/rtl/ffha_pkg.sv */
package ffha_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int ALIGN_BYTES = 8;
    localparam int BSZ_W      = 23;

    localparam logic [BSZ_W-1:0] SAT23      = 23'h7FFFFF;
    localparam logic [23:0]      HEAP_MIN   = 24'd64;
    localparam logic [23:0]      HEAP_MAX   = 24'h800000;
    localparam logic [6:0]       HDR_MIN    = 7'd8;
    localparam logic [6:0]       HDR_MAX    = 7'd64;
    localparam logic [31:0]      BASE_RESET = 32'h00800000;
    localparam logic [23:0]      HEAP_RESET = 24'h400000;
    localparam logic [6:0]       HDR_RESET  = 7'd20;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_INIT    = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DFREE   = 3'd4;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_HEAP = 2'd1;
    localparam logic [1:0] CFG_HDR  = 2'd2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [BSZ_W-1:0]  t_bsz;

    localparam t_link NIL_LINK = t_link'(MAX_BLOCKS);

    typedef struct packed {
        t_bsz  offset;
        t_bsz  size;
        logic  is_free;
        t_link next;
        t_link prev;
    } t_entry;

    typedef struct packed {
        logic [31:0] base;
        logic [23:0] heap;
        logic [6:0]  hdr;
    } t_cfg;

    function automatic logic link_ok(t_link l);
        return l < NIL_LINK;
    endfunction

    function automatic t_bsz sat_add(t_bsz a, logic [23:0] b);
        logic [24:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, SAT23}) ? SAT23 : s[BSZ_W-1:0];
    endfunction

endpackage

/* hw/rtl/ffha_if.sv */
interface ffha_req_if import ffha_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] request_bytes;
    logic [31:0] release_address;

    modport source(output valid, action, request_bytes, release_address, input ready);
    modport sink(input valid, action, request_bytes, release_address, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] data_address;
    logic [23:0] used_bytes;
    logic [23:0] free_bytes;

    modport source(output valid, status, data_address, used_bytes, free_bytes, input ready);
    modport sink(input valid, status, data_address, used_bytes, free_bytes, output ready);
endinterface

/* hw/rtl/ffha_ram.sv */
module ffha_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ffha_ctrl.sv */
module ffha_ctrl import ffha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_release_address,
    input  logic        i_take,
    output logic        o_idle,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_data_address,
    output t_bsz        o_used
);

    localparam logic [3:0] S_BOOT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_WALK = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_SPA  = 4'd5;
    localparam logic [3:0] S_TAKE = 4'd6;
    localparam logic [3:0] S_RN   = 4'd7;
    localparam logic [3:0] S_RP   = 4'd8;
    localparam logic [3:0] S_WP   = 4'd9;
    localparam logic [3:0] S_FIX  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam t_idx LAST_IDX = t_idx'(MAX_BLOCKS - 1);

    logic [3:0]            r_state, n_state;
    t_idx                  r_cur_idx, n_cur_idx;
    t_entry                r_cur, n_cur;
    t_idx                  r_steps, n_steps;
    logic [32:0]           r_need, n_need;
    logic [33:0]           r_need_split, n_need_split;
    logic [31:0]           r_rel, n_rel;
    logic                  r_is_alloc, n_is_alloc;
    t_idx                  r_scan, n_scan;
    t_idx                  r_fix_idx, n_fix_idx;
    t_link                 r_fix_prev, n_fix_prev;
    logic                  r_fix_en, n_fix_en;
    logic                  r_mergep, n_mergep;
    t_entry                r_pent, n_pent;
    t_bsz                  r_used, n_used;
    logic [2:0]            r_status, n_status;
    logic [31:0]           r_addr, n_addr;
    logic [MAX_BLOCKS-1:0] r_in_use, n_in_use;

    logic        w_we, w_re;
    t_idx        w_waddr, w_raddr;
    t_entry      w_wdata, w_rd, w_entry0;
    logic [31:0] w_rd_addr;
    logic [32:0] w_need;
    logic        w_hit, w_mergep;
    logic [23:0] w_amt;

    ffha_ram #(.DEPTH(MAX_BLOCKS), .WIDTH($bits(t_entry))) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    always_comb begin
        w_entry0.offset  = '0;
        w_entry0.size    = (i_cfg.heap > {17'd0, i_cfg.hdr})
                           ? t_bsz'(i_cfg.heap - {17'd0, i_cfg.hdr}) : '0;
        w_entry0.is_free = 1'b1;
        w_entry0.next    = NIL_LINK;
        w_entry0.prev    = NIL_LINK;
        w_rd_addr = i_cfg.base + {9'd0, w_rd.offset} + {25'd0, i_cfg.hdr};
        w_need    = ({1'b0, i_request_bytes} + 33'(ALIGN_BYTES - 1))
                    & ~33'(ALIGN_BYTES - 1);
        w_hit     = r_is_alloc ? (w_rd.is_free && ({10'd0, w_rd.size} >= r_need))
                               : (w_rd_addr == r_rel);
        w_amt     = {1'b0, w_rd.size} + {17'd0, i_cfg.hdr};
        w_mergep  = link_ok(r_cur.prev) && w_rd.is_free;
    end

    always_comb begin
        n_state      = r_state;
        n_cur_idx    = r_cur_idx;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_need       = r_need;
        n_need_split = r_need_split;
        n_rel        = r_rel;
        n_is_alloc   = r_is_alloc;
        n_scan       = r_scan;
        n_fix_idx    = r_fix_idx;
        n_fix_prev   = r_fix_prev;
        n_fix_en     = r_fix_en;
        n_mergep     = r_mergep;
        n_pent       = r_pent;
        n_used       = r_used;
        n_status     = r_status;
        n_addr       = r_addr;
        n_in_use     = r_in_use;
        w_we    = 1'b0;
        w_waddr = r_cur_idx;
        w_wdata = r_cur;
        w_re    = 1'b0;
        w_raddr = '0;
        case (r_state)
            S_BOOT, S_INIT: begin
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = w_entry0;
                n_in_use = {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
                n_used   = '0;
                n_state  = (r_state == S_BOOT) ? S_IDLE : S_DONE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_status     = ST_OK;
                    n_addr       = '0;
                    n_steps      = '0;
                    n_cur_idx    = '0;
                    n_fix_en     = 1'b0;
                    n_mergep     = 1'b0;
                    n_is_alloc   = (i_action == ACT_ALLOC);
                    n_need       = w_need;
                    n_need_split = {1'b0, w_need} + {27'd0, i_cfg.hdr} + 34'(ALIGN_BYTES);
                    n_rel        = i_release_address;
                    case (i_action)
                        ACT_ALLOC: begin
                            if (i_request_bytes == '0) begin
                                n_status = ST_ZERO;
                                n_state  = S_DONE;
                            end else begin
                                w_re    = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        ACT_RELEASE: begin
                            if (i_release_address == '0) begin
                                n_status = ST_ZERO;
                                n_state  = S_DONE;
                            end else begin
                                w_re    = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        ACT_INIT: begin
                            n_state = S_INIT;
                        end
                        default: begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_hit) begin
                    n_cur = w_rd;
                    if (r_is_alloc) begin
                        n_addr = w_rd_addr;
                        if ({11'd0, w_rd.size} >= r_need_split) begin
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_TAKE;
                        end
                    end else if (w_rd.is_free) begin
                        n_status = ST_DFREE;
                        n_state  = S_DONE;
                    end else begin
                        n_used        = ({1'b0, r_used} > w_amt) ? (r_used - w_amt[BSZ_W-1:0]) : '0;
                        n_cur.is_free = 1'b1;
                        w_re          = link_ok(w_rd.next);
                        w_raddr       = w_rd.next[IDX_W-1:0];
                        n_state       = S_RN;
                    end
                end else if ((r_steps == LAST_IDX) || !link_ok(w_rd.next)) begin
                    n_status = r_is_alloc ? ST_NOSPACE : ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_steps   = r_steps + 1'b1;
                    n_cur_idx = w_rd.next[IDX_W-1:0];
                    w_re      = 1'b1;
                    w_raddr   = w_rd.next[IDX_W-1:0];
                end
            end
            S_SCAN: begin
                if (!r_in_use[r_scan]) begin
                    n_state = S_SPA;
                end else if (r_scan == LAST_IDX) begin
                    n_state = S_TAKE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_SPA: begin
                w_we            = 1'b1;
                w_waddr         = r_scan;
                w_wdata.offset  = t_bsz'(r_cur.offset + t_bsz'(i_cfg.hdr) + r_need[BSZ_W-1:0]);
                w_wdata.size    = r_cur.size - r_need[BSZ_W-1:0] - t_bsz'(i_cfg.hdr);
                w_wdata.is_free = 1'b1;
                w_wdata.next    = r_cur.next;
                w_wdata.prev    = t_link'(r_cur_idx);
                n_in_use[r_scan] = 1'b1;
                n_fix_idx  = r_cur.next[IDX_W-1:0];
                n_fix_prev = t_link'(r_scan);
                n_fix_en   = link_ok(r_cur.next);
                w_re       = link_ok(r_cur.next);
                w_raddr    = r_cur.next[IDX_W-1:0];
                n_cur.next = t_link'(r_scan);
                n_cur.size = r_need[BSZ_W-1:0];
                n_state    = S_TAKE;
            end
            S_TAKE: begin
                w_we            = 1'b1;
                w_wdata.is_free = 1'b0;
                n_used  = sat_add(r_used, {1'b0, r_cur.size} + {17'd0, i_cfg.hdr});
                n_state = r_fix_en ? S_FIX : S_DONE;
            end
            S_RN: begin
                if (link_ok(r_cur.next) && w_rd.is_free) begin
                    n_cur.size = sat_add(r_cur.size, {1'b0, w_rd.size} + {17'd0, i_cfg.hdr});
                    n_cur.next = w_rd.next;
                    n_in_use[r_cur.next[IDX_W-1:0]] = 1'b0;
                end
                w_re    = link_ok(r_cur.prev);
                w_raddr = r_cur.prev[IDX_W-1:0];
                n_state = S_RP;
            end
            S_RP: begin
                w_we        = 1'b1;
                n_mergep    = w_mergep;
                n_pent      = w_rd;
                n_pent.size = sat_add(w_rd.size, {1'b0, r_cur.size} + {17'd0, i_cfg.hdr});
                n_pent.next = r_cur.next;
                if (w_mergep) begin
                    n_in_use[r_cur_idx] = 1'b0;
                end
                n_fix_idx  = r_cur.next[IDX_W-1:0];
                n_fix_prev = w_mergep ? r_cur.prev : t_link'(r_cur_idx);
                n_fix_en   = link_ok(r_cur.next);
                w_re       = link_ok(r_cur.next);
                w_raddr    = r_cur.next[IDX_W-1:0];
                n_state    = S_WP;
            end
            S_WP: begin
                w_we    = r_mergep;
                w_waddr = r_cur.prev[IDX_W-1:0];
                w_wdata = r_pent;
                n_state = r_fix_en ? S_FIX : S_DONE;
            end
            S_FIX: begin
                w_we         = 1'b1;
                w_waddr      = r_fix_idx;
                w_wdata      = w_rd;
                w_wdata.prev = r_fix_prev;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_BOOT;
            r_used     <= '0;
            r_in_use   <= {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
            r_fix_en   <= 1'b0;
            r_mergep   <= 1'b0;
            r_is_alloc <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_in_use   <= n_in_use;
            r_fix_en   <= n_fix_en;
            r_mergep   <= n_mergep;
            r_is_alloc <= n_is_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_idx    <= n_cur_idx;
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_need       <= n_need;
        r_need_split <= n_need_split;
        r_rel        <= n_rel;
        r_scan       <= n_scan;
        r_fix_idx    <= n_fix_idx;
        r_fix_prev   <= n_fix_prev;
        r_pent       <= n_pent;
        r_status     <= n_status;
        r_addr       <= n_addr;
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_data_address = r_addr;
    assign o_used         = r_used;

endmodule

/* hw/rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator: one request at a time. An allocate or release walks the
// block chain one table entry per cycle through a block memory with one read port and
// one write port, visiting at most 256 entries. An allocate whose block is large enough
// to split then searches the entry-in-use bits for a spare entry, one per cycle; a
// release that hits a used block then merges it with its free neighbours. After reset
// the block builds the initial free block in its boot state before it takes requests.
module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    ffha_req_if.sink     i_req,
    ffha_rsp_if.source   o_rsp
);

    logic [31:0] r_heap_base;
    logic [23:0] r_heap_bytes;
    logic [6:0]  r_header_bytes;
    t_cfg        w_cfg;

    logic        w_idle, w_done, w_take;
    logic [2:0]  w_status;
    logic [31:0] w_addr;
    t_bsz        w_used;
    logic [23:0] w_used_ext;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_addr;
    logic [23:0] r_out_used;
    logic [23:0] r_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base    <= BASE_RESET;
            r_heap_bytes   <= HEAP_RESET;
            r_header_bytes <= HDR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE: r_heap_base    <= i_cfg_data;
                CFG_HEAP: r_heap_bytes   <= i_cfg_data[23:0];
                CFG_HDR:  r_header_bytes <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.base = r_heap_base;
        w_cfg.heap = (r_heap_bytes < HEAP_MIN) ? HEAP_MIN
                   : (r_heap_bytes > HEAP_MAX) ? HEAP_MAX : r_heap_bytes;
        w_cfg.hdr  = (r_header_bytes < HDR_MIN) ? HDR_MIN
                   : (r_header_bytes > HDR_MAX) ? HDR_MAX : r_header_bytes;
    end

    ffha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_start          (i_req.valid && w_idle),
        .i_action         (i_req.action),
        .i_request_bytes  (i_req.request_bytes),
        .i_release_address(i_req.release_address),
        .i_take           (w_take),
        .o_idle           (w_idle),
        .o_done           (w_done),
        .o_status         (w_status),
        .o_data_address   (w_addr),
        .o_used           (w_used)
    );

    assign i_req.ready = w_idle;
    assign w_take      = w_done && (!r_out_valid || o_rsp.ready);
    assign w_used_ext  = {1'b0, w_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_status <= w_status;
            r_out_addr   <= w_addr;
            r_out_used   <= w_used_ext;
            r_out_free   <= (w_cfg.heap > w_used_ext) ? (w_cfg.heap - w_used_ext) : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.data_address = r_out_addr;
    assign o_rsp.used_bytes   = r_out_used;
    assign o_rsp.free_bytes   = r_out_free;

endmodule

/* hw/rtl/ffha_checker.sv */
module ffha_checker import ffha_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_data_address
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_data_address))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= ST_DFREE))
        else $error("unknown status code");

    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_data_address == '0))
        else $error("address given with failing status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_data_address(o_rsp.data_address)
);

/* test/first_fit_heap_allocator_test.sv */
`timescale 1ns / 100ps

module first_fit_heap_allocator_test;
    import ffha_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] req_bytes;
        logic [31:0] rel_addr;
    } t_alloc_req;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [23:0] used;
        logic [23:0] free;
    } t_alloc_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_BASE;
    logic [31:0] cfg_data = '0;

    ffha_req_if req_if();
    ffha_rsp_if rsp_if();

    first_fit_heap_allocator DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block state.
    logic [31:0]  heap_base;
    logic [23:0]  heap_len;
    logic [6:0]   hdr_size;
    int unsigned  blk_off  [MAX_BLOCKS];
    int unsigned  blk_size [MAX_BLOCKS];
    bit           blk_free [MAX_BLOCKS];
    int unsigned  blk_next [MAX_BLOCKS];
    int unsigned  blk_prev [MAX_BLOCKS];
    bit           blk_live [MAX_BLOCKS];
    int unsigned  used_sum;

    t_alloc_req pending_reqs[$];
    t_alloc_rsp expected_rsps[$];
    t_alloc_req drv_item;
    t_alloc_rsp exp_item;

    bit src_idle = 1'b0;
    bit snk_idle = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int status_seen[8];
    int idle_cycles = 0;

    function automatic int unsigned eff_heap();
        if (heap_len < HEAP_MIN) return HEAP_MIN;
        if (heap_len > HEAP_MAX) return HEAP_MAX;
        return heap_len;
    endfunction

    function automatic int unsigned eff_hdr();
        if (hdr_size < HDR_MIN) return HDR_MIN;
        if (hdr_size > HDR_MAX) return HDR_MAX;
        return hdr_size;
    endfunction

    function automatic int unsigned sat23(longint unsigned a, longint unsigned b);
        return (a + b > SAT23) ? SAT23 : int'(a + b);
    endfunction

    function automatic logic [31:0] data_addr(int unsigned e);
        return heap_base + blk_off[e] + eff_hdr();
    endfunction

    function automatic void rebuild_heap();
        int unsigned h;
        int unsigned hd;
        h = eff_heap();
        hd = eff_hdr();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_off[i] = 0;
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
            blk_next[i] = MAX_BLOCKS;
            blk_prev[i] = MAX_BLOCKS;
            blk_live[i] = 1'b0;
        end
        blk_size[0] = (h > hd) ? h - hd : 0;
        blk_free[0] = 1'b1;
        blk_live[0] = 1'b1;
        used_sum = 0;
    endfunction

    function automatic void coalesce(int unsigned b);
        int unsigned hd;
        int unsigned n;
        int unsigned p;
        hd = eff_hdr();
        n = blk_next[b];
        if (n < MAX_BLOCKS && blk_free[n]) begin
            blk_size[b] = sat23(blk_size[b], hd + blk_size[n]);
            blk_next[b] = blk_next[n];
            blk_live[n] = 1'b0;
            if (blk_next[b] < MAX_BLOCKS) blk_prev[blk_next[b]] = b;
        end
        p = blk_prev[b];
        if (p < MAX_BLOCKS && blk_free[p]) begin
            blk_size[p] = sat23(blk_size[p], hd + blk_size[b]);
            blk_next[p] = blk_next[b];
            if (blk_next[b] < MAX_BLOCKS) blk_prev[blk_next[b]] = p;
            blk_live[b] = 1'b0;
        end
    endfunction

    function automatic logic [2:0] alloc_block(logic [31:0] req, output logic [31:0] addr);
        longint unsigned need;
        int unsigned hd;
        int unsigned cur;
        int unsigned sp;
        int unsigned nx;
        hd = eff_hdr();
        addr = '0;
        if (req == 0) return ST_ZERO;
        need = ((longint'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        cur = 0;
        for (int steps = 0; steps < MAX_BLOCKS && cur < MAX_BLOCKS; steps++) begin
            if (blk_free[cur] && blk_size[cur] >= need) begin
                sp = MAX_BLOCKS;
                for (int i = MAX_BLOCKS - 1; i >= 0; i--) if (!blk_live[i]) sp = i;
                if (blk_size[cur] >= need + hd + ALIGN_BYTES && sp < MAX_BLOCKS) begin
                    nx = blk_next[cur];
                    blk_off[sp] = (blk_off[cur] + hd + int'(need)) & SAT23;
                    blk_size[sp] = blk_size[cur] - int'(need) - hd;
                    blk_free[sp] = 1'b1;
                    blk_next[sp] = nx;
                    blk_prev[sp] = cur;
                    blk_live[sp] = 1'b1;
                    if (nx < MAX_BLOCKS) blk_prev[nx] = sp;
                    blk_next[cur] = sp;
                    blk_size[cur] = int'(need);
                end
                blk_free[cur] = 1'b0;
                used_sum = sat23(used_sum, blk_size[cur] + hd);
                addr = data_addr(cur);
                return ST_OK;
            end
            cur = blk_next[cur];
        end
        return ST_NOSPACE;
    endfunction

    function automatic logic [2:0] release_block(logic [31:0] addr);
        int unsigned cur;
        int unsigned amt;
        if (addr == 0) return ST_ZERO;
        cur = 0;
        for (int steps = 0; steps < MAX_BLOCKS && cur < MAX_BLOCKS; steps++) begin
            if (data_addr(cur) == addr) begin
                if (blk_free[cur]) return ST_DFREE;
                amt = blk_size[cur] + eff_hdr();
                used_sum = (used_sum > amt) ? used_sum - amt : 0;
                blk_free[cur] = 1'b1;
                coalesce(cur);
                return ST_OK;
            end
            cur = blk_next[cur];
        end
        return ST_INVALID;
    endfunction

    // Queues one request and the response that the shadow state predicts for it.
    function automatic void queue_request(logic [1:0] act, logic [31:0] req, logic [31:0] rel);
        t_alloc_req r;
        t_alloc_rsp e;
        int unsigned h;
        r.act = act;
        r.req_bytes = req;
        r.rel_addr = rel;
        e.addr = '0;
        case (act)
            ACT_ALLOC: begin
                e.status = alloc_block(req, e.addr);
            end
            ACT_RELEASE: begin
                e.status = release_block(rel);
            end
            ACT_INIT: begin
                rebuild_heap();
                e.status = ST_OK;
            end
            default: begin
                e.status = ST_INVALID;
            end
        endcase
        h = eff_heap();
        e.used = used_sum[23:0];
        e.free = (h > used_sum) ? 24'(h - used_sum) : '0;
        pending_reqs.push_back(r);
        expected_rsps.push_back(e);
    endfunction

    // Data address of a random block in the chain, used or free as asked.
    function automatic logic [31:0] pick_block(bit want_free);
        logic [31:0] found[$];
        int unsigned cur;
        cur = 0;
        for (int steps = 0; steps < MAX_BLOCKS && cur < MAX_BLOCKS; steps++) begin
            if (blk_free[cur] == want_free) found.push_back(data_addr(cur));
            cur = blk_next[cur];
        end
        if (found.size() == 0) return $urandom;
        return found[$urandom_range(found.size() - 1)];
    endfunction

    function automatic logic [31:0] random_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 256);
        if (r < 88) return $urandom_range(257, 65536);
        if (r < 94) return 0;
        return $urandom;
    endfunction

    function automatic void queue_random();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(99);
        k = $urandom_range(99);
        if (r < 48) begin
            queue_request(ACT_ALLOC, random_size(), $urandom);
        end else if (r < 94) begin
            if (k < 70) queue_request(ACT_RELEASE, $urandom, pick_block(1'b0));
            else if (k < 80) queue_request(ACT_RELEASE, $urandom, pick_block(1'b1));
            else if (k < 88) queue_request(ACT_RELEASE, $urandom, $urandom);
            else if (k < 94) queue_request(ACT_RELEASE, $urandom, pick_block(1'b0) + 1);
            else queue_request(ACT_RELEASE, $urandom, '0);
        end else if (r < 97) begin
            queue_request(ACT_INIT, $urandom, $urandom);
        end else begin
            queue_request(ACT_SPARE, $urandom, $urandom);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            CFG_BASE: heap_base = value;
            CFG_HEAP: heap_len = value[23:0];
            default:  hdr_size = value[6:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.action <= ACT_INIT;
            req_if.request_bytes <= '0;
            req_if.release_address <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && (!src_idle || $urandom_range(99) >= 50)) begin
                drv_item = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.action <= drv_item.act;
                req_if.request_bytes <= drv_item.req_bytes;
                req_if.release_address <= drv_item.rel_addr;
                sent++;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= !(snk_idle && $urandom_range(99) < 50);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            checked++;
            status_seen[rsp_if.status]++;
            if (expected_rsps.size() == 0) begin
                $error("unexpected response: status %0d address %h", rsp_if.status,
                       rsp_if.data_address);
                errors++;
            end else begin
                exp_item = expected_rsps.pop_front();
                if (rsp_if.status !== exp_item.status) begin
                    $error("status: expected %0d, got %0d", exp_item.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.data_address !== exp_item.addr) begin
                    $error("data_address: expected %h, got %h", exp_item.addr,
                           rsp_if.data_address);
                    errors++;
                end
                if (rsp_if.used_bytes !== exp_item.used) begin
                    $error("used_bytes: expected %0d, got %0d", exp_item.used,
                           rsp_if.used_bytes);
                    errors++;
                end
                if (rsp_if.free_bytes !== exp_item.free) begin
                    $error("free_bytes: expected %0d, got %0d", exp_item.free,
                           rsp_if.free_bytes);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (pending_reqs.size() != 0 || req_if.valid
                         || expected_rsps.size() != 0) begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d responses outstanding.",
                         expected_rsps.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.action = ACT_INIT;
        req_if.request_bytes = '0;
        req_if.release_address = '0;
        rsp_if.ready = 1'b0;
        heap_base = BASE_RESET;
        heap_len = HEAP_RESET;
        hdr_size = HDR_RESET;
        rebuild_heap();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset configuration.
        queue_request(ACT_ALLOC, 32'd0, '0);
        queue_request(ACT_ALLOC, 32'd1, '0);
        queue_request(ACT_ALLOC, 32'hFFFF_FFFF, '0);
        queue_request(ACT_ALLOC, 32'd8, '0);
        queue_request(ACT_ALLOC, 32'd100, '0);
        queue_request(ACT_RELEASE, '0, '0);
        queue_request(ACT_RELEASE, '0, BASE_RESET + HDR_RESET + 1);
        queue_request(ACT_RELEASE, '0, BASE_RESET + 32 + HDR_RESET + HDR_RESET);
        queue_request(ACT_RELEASE, '0, BASE_RESET + 32 + HDR_RESET + HDR_RESET);
        queue_request(ACT_RELEASE, '0, BASE_RESET + HDR_RESET);
        queue_request(ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(ACT_ALLOC, 32'd4194000, '0);
        queue_request(ACT_ALLOC, 32'd64, '0);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_ALLOC, 32'(HEAP_RESET - HDR_RESET), '0);
        drain();

        // Smallest heap with the largest header, registers beyond their ranges.
        write_reg(CFG_BASE, 32'hFFFF_FFF0);
        write_reg(CFG_HEAP, 32'h0000_0000);
        write_reg(CFG_HDR, 32'h0000_007F);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_ALLOC, 32'd1, '0);
        queue_request(ACT_RELEASE, '0, 32'h0000_0030);
        drain();
        write_reg(CFG_HDR, 32'h0000_0000);
        queue_request(ACT_INIT, '0, '0);
        queue_request(ACT_ALLOC, 32'd40, '0);
        queue_request(ACT_ALLOC, 32'd9, '0);
        queue_request(ACT_RELEASE, '0, 32'hFFFF_FFF8);
        drain();

        // Largest heap, many tiny blocks until the entry table is exhausted.
        write_reg(CFG_BASE, 32'h0000_0000);
        write_reg(CFG_HEAP, 32'h00FF_FFFF);
        write_reg(CFG_HDR, 32'd8);
        queue_request(ACT_INIT, '0, '0);
        for (int i = 0; i < 262; i++) queue_request(ACT_ALLOC, 32'd8, '0);
        queue_request(ACT_ALLOC, 32'h007F_0000, '0);
        for (int i = 0; i < 20; i++) queue_random();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            src_idle = (phase == 1) || (phase == 3);
            snk_idle = (phase == 2) || (phase == 3);
            write_reg(CFG_BASE, $urandom);
            write_reg(CFG_HEAP, ($urandom_range(3) == 0) ? $urandom : $urandom_range(64, 8192));
            write_reg(CFG_HDR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(8, 64));
            if (phase != 2) queue_request(ACT_INIT, '0, '0);
            if (phase == 0) hold_go <= 1'b1;
            for (int i = 0; i < 20; i++) queue_random();
            drain();
            // Header change over a live chain, without init.
            write_reg(CFG_HDR, $urandom_range(8, 64));
            for (int i = 0; i < 5; i++) queue_random();
            drain();
        end

        $display("Sent %0d requests, checked %0d responses.", sent, checked);
        $display("Statuses ok %0d, null %0d, no space %0d, invalid %0d, double free %0d.",
                 status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_NOSPACE],
                 status_seen[ST_INVALID], status_seen[ST_DFREE]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
